/* rtl/amge_pkg.sv */
// shared constants and types for the adjacency matrix graph engine
`default_nettype none
package amge_pkg;
  localparam int MaxVerticesDefault = 32;

  localparam logic [3:0] MODE_ADD_VERTEX = 4'd0;
  localparam logic [3:0] MODE_DELETE     = 4'd1;
  localparam logic [3:0] MODE_ADD_EDGE   = 4'd2;
  localparam logic [3:0] MODE_CHECK_VERT = 4'd3;
  localparam logic [3:0] MODE_CHECK_EDGE = 4'd4;
  localparam logic [3:0] MODE_ANY_EDGE   = 4'd5;
  localparam logic [3:0] MODE_DFS        = 4'd6;
  localparam logic [3:0] MODE_TOPO       = 4'd7;
  localparam logic [3:0] MODE_EMPTY      = 4'd8;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_NOVERT = 3'd1;
  localparam logic [2:0] ST_CYCLE  = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] vertex;
    logic       flag;
    logic [5:0] count;
    logic       last;
  } result_t;
endpackage
`default_nettype wire

/* rtl/amge_out_reg.sv */
// output register stage of the result channel
`default_nettype none
module amge_out_reg
  import amge_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  result_t      res,
  output logic         full,
  input  wire logic    out_stall,
  output logic         out_valid,
  output result_t      out_res
);
  logic    valid_r;
  result_t res_r;

  assign out_valid = valid_r;
  assign out_res   = res_r;
  assign full      = valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end
endmodule
`default_nettype wire

/* rtl/adjacency_matrix_graph_engine_unit.sv */
// graph engine top level: matrix, sequencer and traversal stacks
// delete, any edge, dfs and topological sort step through the matrix; the other commands decode at once
// one command at a time, set by the single sequencer; each result waits for an empty output
// reset: matrix and vertex count cleared at once by synchronous reset
`default_nettype none
module adjacency_matrix_graph_engine_unit
  import amge_pkg::*;
#(
  parameter int MAX_VERTICES = MaxVerticesDefault
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [3:0] in_mode,
  input  wire logic [5:0] in_vertex_a,
  input  wire logic [5:0] in_vertex_b,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_status,
  output logic [5:0]      out_vertex_out,
  output logic            out_flag,
  output logic [5:0]      out_vertex_count,
  output logic            out_last
);
  localparam int NV = MAX_VERTICES;
  localparam int IW = $clog2(NV);
  localparam int CW = $clog2(NV + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_DROW  = 4'd2;
  localparam logic [3:0] S_DCOL  = 4'd3;
  localparam logic [3:0] S_ANY   = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_ROOT  = 4'd6;
  localparam logic [3:0] S_EMIT  = 4'd7;
  localparam logic [3:0] S_SEND  = 4'd8;
  localparam logic [3:0] S_POP   = 4'd9;

  logic [NV-1:0] adj_r [NV];
  logic [CW-1:0] total_r;
  logic [NV-1:0] mark1_r, mark2_r;
  logic [IW-1:0] stk_v_r [NV];
  logic [CW-1:0] stk_n_r [NV];
  logic [IW-1:0] ord_r [NV];
  logic [CW-1:0] sp_r, cnt_r, cur_r, ix_r;
  logic [3:0]    st_r;
  logic [3:0]    mode_r;
  logic [5:0]    a_r, b_r;
  logic [5:0]    nv_r;
  logic          any_r, ret_r;
  result_t       pend_r;

  logic    load, ofull;
  result_t ores;

  amge_out_reg u_out (
    .clk(clk), .rst_n(rst_n), .load(load), .res(pend_r), .full(ofull),
    .out_stall(out_stall), .out_valid(out_valid), .out_res(ores)
  );
  assign out_status       = ores.status;
  assign out_vertex_out   = ores.vertex;
  assign out_flag         = ores.flag;
  assign out_vertex_count = ores.count;
  assign out_last         = ores.last;

  assign in_stall = (st_r != S_IDLE);

  logic          a_ok, b_ok;
  logic [IW-1:0] ai, bi, topv, ci, ixi;
  logic          tb, mk1, mk2;
  assign a_ok = (a_r != 6'd0) && ({1'b0, a_r} <= 7'(total_r));
  assign b_ok = (b_r != 6'd0) && ({1'b0, b_r} <= 7'(total_r));
  assign ai   = IW'(a_r - 6'd1);
  assign bi   = IW'(b_r - 6'd1);
  assign topv = stk_v_r[IW'(sp_r - CW'(1))];
  assign ci   = cur_r[IW-1:0];
  assign ixi  = ix_r[IW-1:0];
  assign tb   = adj_r[topv][ci];
  assign mk1  = mark1_r[ci];
  assign mk2  = mark2_r[ci];

  logic done_w;
  assign done_w = !ofull && !out_valid;
  assign load   = (st_r == S_SEND) && done_w;

  logic          dec_trav;
  logic [3:0]    dec_next;
  result_t       dec_res;
  assign dec_trav = (total_r != '0) && (mode_r == MODE_TOPO || a_ok);

  always_comb begin
    dec_res  = '{status: ST_OK, vertex: 6'd0, flag: 1'b0,
                 count: 6'(total_r), last: 1'b1};
    dec_next = S_SEND;
    case (mode_r)
      MODE_ADD_VERTEX:
        if (total_r >= CW'(NV)) dec_res.status = ST_FULL;
        else dec_res.count = 6'(total_r + CW'(1));
      MODE_DELETE:
        if (!a_ok) dec_res.status = ST_NOVERT;
        else dec_next = S_DROW;
      MODE_ADD_EDGE, MODE_CHECK_EDGE:
        if (!a_ok || !b_ok) dec_res.status = ST_NOVERT;
        else if (mode_r == MODE_CHECK_EDGE) dec_res.flag = adj_r[ai][bi];
      MODE_CHECK_VERT: dec_res.flag = a_ok;
      MODE_ANY_EDGE: dec_next = S_ANY;
      MODE_DFS, MODE_TOPO:
        if (total_r == '0) dec_res.status = ST_EMPTY;
        else if (!dec_trav) dec_res.status = ST_NOVERT;
        else if (mode_r == MODE_DFS) begin
          dec_res.vertex = a_r; dec_res.last = 1'b0; dec_next = S_SCAN;
        end else dec_next = S_ROOT;
      MODE_EMPTY: dec_res.flag = (total_r == '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      total_r <= '0;
      for (int i = 0; i < NV; i++) adj_r[i] <= '0;
    end else begin
      case (st_r)
        S_IDLE: if (in_valid) begin
          mode_r <= in_mode; a_r <= in_vertex_a; b_r <= in_vertex_b;
          st_r <= S_DEC;
        end
        S_DEC: begin
          pend_r <= dec_res;
          st_r   <= dec_next;
          ret_r  <= 1'b0;
          case (mode_r)
            MODE_ADD_VERTEX: if (total_r < CW'(NV)) total_r <= total_r + CW'(1);
            MODE_DELETE: if (a_ok) ix_r <= CW'(ai);
            MODE_ADD_EDGE: if (a_ok && b_ok) adj_r[ai][bi] <= 1'b1;
            MODE_ANY_EDGE: begin
              any_r <= 1'b0; ix_r <= '0;
            end
            MODE_DFS: if (dec_trav) begin
              mark1_r <= NV'(1) << ai; mark2_r <= '0; cnt_r <= '0;
              stk_v_r[0] <= ai; stk_n_r[0] <= '0; sp_r <= CW'(1);
              cur_r <= '0;
            end
            MODE_TOPO: if (dec_trav) begin
              mark1_r <= '0; mark2_r <= '0; cnt_r <= '0; ix_r <= '0;
            end
            default: ;
          endcase
        end
        S_DROW: begin
          if (ix_r + CW'(1) < total_r) begin
            adj_r[ixi] <= adj_r[ixi + IW'(1)]; ix_r <= ix_r + CW'(1);
          end else begin
            adj_r[ixi] <= '0; ix_r <= '0; total_r <= total_r - CW'(1);
            st_r <= S_DCOL;
          end
        end
        S_DCOL: begin
          for (int j = 0; j < NV; j++)
            if (j >= int'(ai))
              adj_r[ixi][j] <= (j + 1 < NV) ? adj_r[ixi][(j + 1) % NV] : 1'b0;
          if (ix_r + CW'(1) >= total_r) begin
            pend_r.count <= 6'(total_r); st_r <= S_SEND;
          end
          ix_r <= ix_r + CW'(1);
        end
        S_ANY: begin
          if (ix_r >= total_r) begin
            pend_r.flag <= any_r; st_r <= S_SEND;
          end else begin
            if (adj_r[ixi] != '0) any_r <= 1'b1;
            ix_r <= ix_r + CW'(1);
          end
        end
        S_ROOT: begin
          if (ix_r >= total_r) st_r <= S_EMIT;
          else if (mark1_r[ixi] || mark2_r[ixi]) ix_r <= ix_r + CW'(1);
          else begin
            mark1_r[ixi] <= 1'b1;
            stk_v_r[0] <= ixi; stk_n_r[0] <= '0; sp_r <= CW'(1);
            cur_r <= '0; st_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sp_r == '0) begin
            if (mode_r == MODE_DFS) begin
              pend_r.last <= 1'b1; ret_r <= 1'b0; st_r <= S_SEND;
            end else begin
              ix_r <= ix_r + CW'(1); st_r <= S_ROOT;
            end
          end else if (cur_r >= total_r) begin
            if (mode_r == MODE_TOPO) begin
              mark1_r[topv] <= 1'b0; mark2_r[topv] <= 1'b1;
              ord_r[cnt_r[IW-1:0]] <= topv; cnt_r <= cnt_r + CW'(1);
            end
            sp_r <= sp_r - CW'(1);
            cur_r <= (sp_r > CW'(1)) ? stk_n_r[IW'(sp_r - CW'(2))] : '0;
          end else if (tb && mode_r == MODE_TOPO && mk1) begin
            pend_r <= '{status: ST_CYCLE, vertex: 6'd0, flag: 1'b0,
                        count: 6'(total_r), last: 1'b1};
            ret_r <= 1'b0; st_r <= S_SEND;
          end else if (tb && !mk1 && !mk2) begin
            stk_n_r[IW'(sp_r - CW'(1))] <= cur_r + CW'(1);
            mark1_r[ci] <= 1'b1;
            stk_v_r[sp_r[IW-1:0]] <= ci; stk_n_r[sp_r[IW-1:0]] <= '0;
            sp_r <= sp_r + CW'(1); cur_r <= '0;
            if (mode_r == MODE_DFS) begin
              nv_r <= 6'(cur_r + CW'(1)); ret_r <= 1'b1; st_r <= S_SEND;
            end
          end else cur_r <= cur_r + CW'(1);
        end
        S_EMIT: begin
          pend_r <= '{status: ST_OK, vertex: 6'(ord_r[IW'(cnt_r - CW'(1))]) + 6'd1,
                      flag: 1'b0, count: 6'(total_r), last: (cnt_r == CW'(1))};
          cnt_r <= cnt_r - CW'(1);
          ret_r <= (cnt_r != CW'(1)); st_r <= S_SEND;
        end
        S_SEND: if (done_w) begin
          if (!ret_r) st_r <= S_POP;
          else if (mode_r == MODE_DFS) begin
            pend_r.vertex <= nv_r; st_r <= S_SCAN;
          end else st_r <= S_EMIT;
        end
        S_POP: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* test/adjacency_matrix_graph_engine_unit_test.sv */
// testbench for the adjacency matrix graph engine: directed and random command requests
module adjacency_matrix_graph_engine_unit_test
  import amge_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV = MaxVerticesDefault;
  localparam int IdleLimit = 20000;

  typedef struct {
    logic [2:0] status;
    logic [5:0] vertex;
    logic       flag;
    logic [5:0] count;
    logic       last;
  } graph_result_t;

  class graph_scoreboard;
    logic [NV-1:0] rows [NV];
    int vert_total;
    graph_result_t pending [$];
    int errors;

    function new();
      foreach (rows[i]) rows[i] = '0;
      vert_total = 0;
      errors = 0;
    endfunction

    function void push(logic [2:0] st, logic [5:0] v, logic fl, logic lst);
      graph_result_t r;
      r.status = st; r.vertex = v; r.flag = fl; r.count = vert_total[5:0]; r.last = lst;
      pending = {pending, r};
    endfunction

    function bit in_range(int v);
      return v >= 1 && v <= vert_total;
    endfunction

    function void remove_at(int k);
      logic [NV-1:0] r;
      for (int i = k; i + 1 < vert_total; i++) rows[i] = rows[i+1];
      rows[vert_total-1] = '0;
      vert_total--;
      for (int i = 0; i < vert_total; i++) begin
        r = '0;
        for (int j = 0; j < NV; j++)
          if (j < k) r[j] = rows[i][j];
          else if (j + 1 < NV) r[j] = rows[i][j+1];
        rows[i] = r;
      end
    endfunction

    function void dfs_walk(int start);
      int marks [NV];
      int stk_v [NV];
      int stk_n [NV];
      int sp, v, t;
      foreach (marks[i]) marks[i] = 0;
      marks[start] = 1;
      push(ST_OK, 6'(start + 1), 1'b0, 1'b0);
      stk_v[0] = start; stk_n[0] = 0; sp = 1;
      while (sp > 0) begin
        v = stk_v[sp-1]; t = stk_n[sp-1];
        while (t < vert_total && !(rows[v][t] && marks[t] == 0)) t++;
        if (t < vert_total) begin
          stk_n[sp-1] = t + 1; marks[t] = 1;
          push(ST_OK, 6'(t + 1), 1'b0, 1'b0);
          stk_v[sp] = t; stk_n[sp] = 0; sp++;
        end else sp--;
      end
      pending[$].last = 1'b1;
    endfunction

    function void topo_sort();
      int marks [NV];
      int stk_v [NV];
      int stk_n [NV];
      int order [NV];
      int sp, v, t, cnt;
      bit pushed;
      cnt = 0;
      foreach (marks[i]) marks[i] = 0;
      for (int i = 0; i < vert_total; i++) begin
        if (marks[i] != 0) continue;
        marks[i] = 1;
        stk_v[0] = i; stk_n[0] = 0; sp = 1;
        while (sp > 0) begin
          v = stk_v[sp-1]; t = stk_n[sp-1]; pushed = 0;
          for (; t < vert_total; t++) begin
            if (!rows[v][t]) continue;
            if (marks[t] == 1) begin
              push(ST_CYCLE, 6'd0, 1'b0, 1'b1);
              return;
            end
            if (marks[t] == 0) begin
              stk_n[sp-1] = t + 1; marks[t] = 1;
              stk_v[sp] = t; stk_n[sp] = 0; sp++;
              pushed = 1;
              break;
            end
          end
          if (!pushed) begin
            marks[v] = 2; order[cnt++] = v; sp--;
          end
        end
      end
      while (cnt > 0) begin
        cnt--;
        push(ST_OK, 6'(order[cnt] + 1), 1'b0, cnt == 0);
      end
    endfunction

    function void note_request(logic [3:0] mode, logic [5:0] a, logic [5:0] b);
      bit any;
      case (mode)
        MODE_ADD_VERTEX: begin
          if (vert_total >= NV) push(ST_FULL, 6'd0, 1'b0, 1'b1);
          else begin
            rows[vert_total] = '0; vert_total++;
            push(ST_OK, 6'd0, 1'b0, 1'b1);
          end
        end
        MODE_DELETE: begin
          if (!in_range(a)) push(ST_NOVERT, 6'd0, 1'b0, 1'b1);
          else begin
            remove_at(a - 1);
            push(ST_OK, 6'd0, 1'b0, 1'b1);
          end
        end
        MODE_ADD_EDGE, MODE_CHECK_EDGE: begin
          if (!in_range(a) || !in_range(b)) push(ST_NOVERT, 6'd0, 1'b0, 1'b1);
          else if (mode == MODE_ADD_EDGE) begin
            rows[a-1][b-1] = 1'b1;
            push(ST_OK, 6'd0, 1'b0, 1'b1);
          end else push(ST_OK, 6'd0, rows[a-1][b-1], 1'b1);
        end
        MODE_CHECK_VERT: push(ST_OK, 6'd0, in_range(a), 1'b1);
        MODE_ANY_EDGE: begin
          any = 0;
          for (int i = 0; i < vert_total; i++) if (rows[i] != '0) any = 1;
          push(ST_OK, 6'd0, any, 1'b1);
        end
        MODE_DFS: begin
          if (vert_total == 0) push(ST_EMPTY, 6'd0, 1'b0, 1'b1);
          else if (!in_range(a)) push(ST_NOVERT, 6'd0, 1'b0, 1'b1);
          else dfs_walk(a - 1);
        end
        MODE_TOPO: begin
          if (vert_total == 0) push(ST_EMPTY, 6'd0, 1'b0, 1'b1);
          else topo_sort();
        end
        MODE_EMPTY: push(ST_OK, 6'd0, vert_total == 0, 1'b1);
        default: push(ST_OK, 6'd0, 1'b0, 1'b1);
      endcase
    endfunction

    function void check_result(graph_result_t got);
      graph_result_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result status=%0d vertex=%0d", got.status, got.vertex);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status) begin
        $error("status expected %0d actual %0d", exp_r.status, got.status); errors++;
      end
      if (got.vertex !== exp_r.vertex) begin
        $error("vertex_out expected %0d actual %0d", exp_r.vertex, got.vertex); errors++;
      end
      if (got.flag !== exp_r.flag) begin
        $error("flag expected %0d actual %0d", exp_r.flag, got.flag); errors++;
      end
      if (got.count !== exp_r.count) begin
        $error("vertex_count expected %0d actual %0d", exp_r.count, got.count); errors++;
      end
      if (got.last !== exp_r.last) begin
        $error("last expected %0d actual %0d", exp_r.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_mode = '0;
  logic [5:0] in_vertex_a = '0;
  logic [5:0] in_vertex_b = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [2:0] out_status;
  logic [5:0] out_vertex_out;
  logic out_flag;
  logic [5:0] out_vertex_count;
  logic out_last;

  graph_scoreboard board = new();
  bit src_idle_on = 1;
  bit sink_idle_on = 1;
  bit sink_hold = 0;
  bit stim_done = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  adjacency_matrix_graph_engine_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_mode), .in_vertex_a(in_vertex_a), .in_vertex_b(in_vertex_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_vertex_out(out_vertex_out), .out_flag(out_flag),
    .out_vertex_count(out_vertex_count), .out_last(out_last)
  );

  // result side: sample and decide the next stall
  always @(posedge clk) begin
    graph_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.status = out_status; got.vertex = out_vertex_out; got.flag = out_flag;
      got.count = out_vertex_count; got.last = out_last;
      board.check_result(got);
    end
    if (!rst_n) out_stall <= 1'b1;
    else out_stall <= sink_hold || (sink_idle_on && $urandom_range(99) < 20);
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send(logic [3:0] mode, logic [5:0] a, logic [5:0] b);
    if (src_idle_on && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (src_idle_on && $urandom_range(99) < 20) @(posedge clk);
    end
    in_valid <= 1'b1; in_mode <= mode; in_vertex_a <= a; in_vertex_b <= b;
    do @(posedge clk); while (in_stall);
    board.note_request(mode, a, b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(int n);
    int r, vt;
    logic [5:0] a, b;
    for (int i = 0; i < n; i++) begin
      vt = board.vert_total;
      r = $urandom_range(99);
      a = (vt > 0 && $urandom_range(9) < 8) ? 6'($urandom_range(vt, 1)) : 6'($urandom);
      b = (vt > 0 && $urandom_range(9) < 8) ? 6'($urandom_range(vt, 1)) : 6'($urandom);
      if (r < 18) send(MODE_ADD_VERTEX, 6'($urandom), 6'($urandom));
      else if (r < 24) send(MODE_DELETE, a, b);
      else if (r < 50) send(MODE_ADD_EDGE, a, b);
      else if (r < 56) send(MODE_CHECK_VERT, a, b);
      else if (r < 64) send(MODE_CHECK_EDGE, a, b);
      else if (r < 68) send(MODE_ANY_EDGE, a, b);
      else if (r < 80) send(MODE_DFS, a, b);
      else if (r < 90) send(MODE_TOPO, a, b);
      else if (r < 94) send(MODE_EMPTY, a, b);
      else send(4'($urandom_range(15, 9)), a, b);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed
    send(MODE_DFS, 6'd1, 6'd0);
    send(MODE_TOPO, 6'd0, 6'd0);
    send(MODE_EMPTY, 6'd0, 6'd0);
    send(MODE_DELETE, 6'd1, 6'd0);
    send(MODE_ADD_VERTEX, 6'd0, 6'd0);
    send(MODE_ADD_VERTEX, 6'd63, 6'd63);
    send(MODE_ADD_VERTEX, 6'd0, 6'd0);
    send(MODE_ADD_EDGE, 6'd1, 6'd2);
    send(MODE_ADD_EDGE, 6'd2, 6'd3);
    send(MODE_ADD_EDGE, 6'd0, 6'd1);
    send(MODE_ADD_EDGE, 6'd1, 6'd63);
    send(MODE_CHECK_EDGE, 6'd1, 6'd2);
    send(MODE_CHECK_EDGE, 6'd2, 6'd1);
    send(MODE_CHECK_EDGE, 6'd63, 6'd1);
    send(MODE_CHECK_VERT, 6'd3, 6'd0);
    send(MODE_CHECK_VERT, 6'd0, 6'd0);
    send(MODE_ANY_EDGE, 6'd0, 6'd0);
    send(MODE_DFS, 6'd1, 6'd0);
    send(MODE_DFS, 6'd63, 6'd0);
    send(MODE_TOPO, 6'd0, 6'd0);
    send(MODE_ADD_EDGE, 6'd3, 6'd3);
    send(MODE_TOPO, 6'd0, 6'd0);
    send(MODE_DELETE, 6'd2, 6'd0);
    send(4'd15, 6'd63, 6'd63);
    drain();
    // fill to full
    src_idle_on = 0; sink_idle_on = 0;
    repeat (NV) send(MODE_ADD_VERTEX, 6'($urandom), 6'($urandom));
    for (int i = 0; i < 30; i++)
      send(MODE_ADD_EDGE, 6'($urandom_range(NV, 1)), 6'($urandom_range(NV, 1)));
    send(MODE_ADD_EDGE, 6'd32, 6'd32);
    send(MODE_DFS, 6'd32, 6'd0);
    send(MODE_TOPO, 6'd0, 6'd0);
    src_idle_on = 1; sink_idle_on = 1;
    // long receiver hold-off while requests keep coming
    fork
      begin
        sink_hold = 1;
        repeat (400) @(posedge clk);
        sink_hold = 0;
      end
      begin
        repeat (12) send(MODE_CHECK_VERT, 6'($urandom), 6'($urandom));
        send(MODE_DFS, 6'd1, 6'd0);
        drain();
      end
    join
    // empty out
    while (board.vert_total > 0) send(MODE_DELETE, 6'($urandom_range(board.vert_total, 1)), 6'd0);
    send(MODE_EMPTY, 6'd0, 6'd0);
    send_random(100);
    drain();
    send_random(100);
    stim_done = 1;
    drain();
    repeat (2000) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

/* adjacency_matrix_graph_engine_unit.f */
rtl/amge_pkg.sv
rtl/amge_out_reg.sv
rtl/adjacency_matrix_graph_engine_unit.sv
test/adjacency_matrix_graph_engine_unit_test.sv
